[design/lgrs_pkg.sv]
// Shared types and constants for the Life row stencil unit.
// No dependencies; every other design file imports this package.
package lgrs_pkg;

	localparam int ROW_BITS        = 64;
	localparam int CFG_W           = 7;
	localparam int MAX_COLUMNS_DEF = 64;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int NBR_CNT_W       = 4;

	localparam logic [CFG_W-1:0]     COLS_RESET    = 7'd64;
	localparam logic [NBR_CNT_W-1:0] BIRTH_COUNT   = 4'd3;
	localparam logic [NBR_CNT_W-1:0] SURVIVE_COUNT = 4'd2;

	typedef struct packed {
		logic [ROW_BITS-1:0] row_cells;
		logic                final_row;
	} lgrs_in_t;

	typedef struct packed {
		logic [ROW_BITS-1:0] next_cells;
		logic                grid_done;
	} lgrs_out_t;

	// One write request into the result queue.
	typedef struct packed {
		logic      valid;
		lgrs_out_t data;
	} lgrs_push_t;

endpackage

[design/lgrs_lane.sv]
// One cell of the B3/S23 rule: 3x3 window in, next state out.
// Depends on lgrs_pkg for the neighbor count thresholds.
module lgrs_lane (
	input  logic [7:0] nbrs,
	input  logic       center,
	output logic       next
);
	import lgrs_pkg::*;

	logic [NBR_CNT_W-1:0] cnt;

	always_comb begin
		cnt = '0;
		for (int k = 0; k < 8; k++) begin
			cnt = cnt + NBR_CNT_W'(nbrs[k]);
		end
		next = (cnt == BIRTH_COUNT) || (center && (cnt == SURVIVE_COUNT));
	end

endmodule

[design/lgrs_stencil.sv]
// Row of parallel cell lanes plus the merge that packs and masks their bits.
// Depends on lgrs_pkg and lgrs_lane.
module lgrs_stencil #(
	parameter int MAX_COLUMNS = lgrs_pkg::MAX_COLUMNS_DEF
) (
	input  logic [MAX_COLUMNS-1:0] above,
	input  logic [MAX_COLUMNS-1:0] mid,
	input  logic [MAX_COLUMNS-1:0] below,
	input  logic [MAX_COLUMNS-1:0] mask,
	output logic [MAX_COLUMNS-1:0] next
);
	import lgrs_pkg::*;

	logic [MAX_COLUMNS-1:0] lane_out;

	for (genvar i = 0; i < MAX_COLUMNS; i++) begin : g_lane
		logic [7:0] nbrs;
		logic       lft_a, lft_m, lft_b, rgt_a, rgt_m, rgt_b;

		// Left edge and right edge neighbors are dead
		if (i > 0) begin : g_lft
			assign lft_a = above[i-1];
			assign lft_m = mid[i-1];
			assign lft_b = below[i-1];
		end else begin : g_lft_edge
			assign lft_a = 1'b0;
			assign lft_m = 1'b0;
			assign lft_b = 1'b0;
		end

		if (i + 1 < MAX_COLUMNS) begin : g_rgt
			assign rgt_a = above[i+1];
			assign rgt_m = mid[i+1];
			assign rgt_b = below[i+1];
		end else begin : g_rgt_edge
			assign rgt_a = 1'b0;
			assign rgt_m = 1'b0;
			assign rgt_b = 1'b0;
		end

		assign nbrs = {lft_a, above[i], rgt_a, lft_m, rgt_m, lft_b, below[i], rgt_b};

		lgrs_lane u_lane (
			.nbrs   (nbrs),
			.center (mid[i]),
			.next   (lane_out[i])
		);
	end

	// Merge: inactive columns come out dead
	assign next = lane_out & mask;

endmodule

[design/lgrs_out_queue.sv]
// Small result queue: up to two writes and one read per cycle.
// Depends on lgrs_pkg for the result and push types.
module lgrs_out_queue #(
	parameter int DEPTH = lgrs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lgrs_pkg::lgrs_push_t  push_a,
	input  lgrs_pkg::lgrs_push_t  push_b,
	output logic                  room_two,
	output logic                  out_valid,
	input  logic                  out_stall,
	output lgrs_pkg::lgrs_out_t   out_data
);
	import lgrs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lgrs_out_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	lgrs_out_t        wdata0, wdata1;
	logic             wr0, wr1, pop;
	logic [CNT_W-1:0] n_push;

	// Pack pushes so the first one always lands at the write pointer
	always_comb begin
		wr0    = push_a.valid || push_b.valid;
		wr1    = push_a.valid && push_b.valid;
		wdata0 = push_a.valid ? push_a.data : push_b.data;
		wdata1 = push_b.data;
		n_push = CNT_W'(push_a.valid) + CNT_W'(push_b.valid);
		pop    = out_valid && !out_stall;
	end

	always_ff @(posedge clk) begin
		if (wr0) begin
			mem_q[wr_ptr_q] <= wdata0;
		end
		if (wr1) begin
			mem_q[PTR_W'(wr_ptr_q + 1'b1)] <= wdata1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= PTR_W'(wr_ptr_q + PTR_W'(n_push));
			if (pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			count_q <= CNT_W'(count_q + n_push - CNT_W'(pop));
		end
	end

	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign room_two  = (count_q <= CNT_W'(DEPTH - 2));

endmodule

[design/life_generation_row_stencil_unit.sv]
// Life (B3/S23) next-generation row stencil, no wrap, one row per transfer.
// Depends on lgrs_pkg, lgrs_stencil, lgrs_out_queue.
//
// Usage:
//  - Input channel (in_valid/in_stall/in_data): one grid row per transfer, top row
//    first; final_row marks the bottom row and closes the grid.
//  - Output channel (out_valid/out_stall/out_data): next-generation rows in order.
//    Row r comes out when row r+1 is taken; the bottom row's transfer yields
//    the row above it (if any), then itself with grid_done set.
//  - cfg_wr_en/cfg_wr_data set active_columns (grid width); write only when idle.
//  - A result enters the queue with its causing transfer; out_* shows the queue head.
//  - Throughput: one row per cycle while in_stall is low; the bottom row can
//    yield two results. Both stencil evaluations run in parallel lanes, one per
//    column, in the same cycle the row is taken; results go to a 4-entry queue.
//  - in_stall rises only when the queue cannot take two more results, so it is
//    a function of registered queue fill; output stalls back up through it.
//  - Reset: width returns to 64, no row held, queue empty. No clearing pass.
module life_generation_row_stencil_unit #(
	parameter int MAX_COLUMNS = lgrs_pkg::MAX_COLUMNS_DEF,
	parameter int QUEUE_DEPTH = lgrs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [lgrs_pkg::CFG_W-1:0]  cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  lgrs_pkg::lgrs_in_t          in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output lgrs_pkg::lgrs_out_t         out_data
);
	import lgrs_pkg::*;

	logic [CFG_W-1:0]       active_cols_q;
	logic [MAX_COLUMNS-1:0] upper_q, middle_q;
	logic                   mid_valid_q;

	logic                   accept, room_two;
	logic [MAX_COLUMNS-1:0] mask, row_m, up_m, mid_m, top_b;
	logic [MAX_COLUMNS-1:0] next_a, next_b;
	lgrs_push_t             push_a, push_b;

	assign accept   = in_valid && !in_stall;
	assign in_stall = !room_two;

	// Column mask; comparing against the lane index also saturates wide settings
	always_comb begin
		for (int i = 0; i < MAX_COLUMNS; i++) begin
			mask[i] = (CFG_W'(i) < active_cols_q);
		end
	end

	// Width may change between rows of a grid, so stored rows are remasked
	assign row_m = in_data.row_cells[MAX_COLUMNS-1:0] & mask;
	assign up_m  = upper_q & mask;
	assign mid_m = middle_q & mask;
	assign top_b = mid_valid_q ? mid_m : '0;

	// Held middle row, completed by the incoming row
	lgrs_stencil #(.MAX_COLUMNS(MAX_COLUMNS)) u_sten_mid (
		.above (up_m),
		.mid   (mid_m),
		.below (row_m),
		.mask  (mask),
		.next  (next_a)
	);

	// Incoming row closed by a dead row below (bottom of grid)
	lgrs_stencil #(.MAX_COLUMNS(MAX_COLUMNS)) u_sten_last (
		.above (top_b),
		.mid   (row_m),
		.below ('0),
		.mask  (mask),
		.next  (next_b)
	);

	always_comb begin
		push_a.valid           = accept && mid_valid_q;
		push_a.data.next_cells = ROW_BITS'(next_a);
		push_a.data.grid_done  = 1'b0;
		push_b.valid           = accept && in_data.final_row;
		push_b.data.next_cells = ROW_BITS'(next_b);
		push_b.data.grid_done  = 1'b1;
	end

	lgrs_out_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_a    (push_a),
		.push_b    (push_b),
		.room_two  (room_two),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_cols_q <= COLS_RESET;
			mid_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				active_cols_q <= cfg_wr_data;
			end
			if (accept) begin
				// bottom row ends the grid; next row starts with a dead row above
				mid_valid_q <= !in_data.final_row;
			end
		end
	end

	// Row window payload; upper is only read while a middle row is held.
	// The middle row moves up as stored, the mask is applied where it is read.
	always_ff @(posedge clk) begin
		if (accept) begin
			upper_q  <= mid_valid_q ? middle_q : '0;
			middle_q <= row_m;
		end
	end

endmodule

[design/lgrs_checker.sv]
// Port-level checks for the Life row stencil unit, bound to the top level.
// Depends on lgrs_pkg and life_generation_row_stencil_unit.
module lgrs_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input lgrs_pkg::lgrs_in_t  in_data,
	input logic                out_valid,
	input logic                out_stall,
	input lgrs_pkg::lgrs_out_t out_data
);
	import lgrs_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// The bottom row always leaves a result pending
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.final_row |=> out_valid)
		else $error("no result after bottom row");

	// Input is held off only while results wait
	a_stall_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	// Results appear only after an accepted row
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |=> !out_valid || $past(in_valid && !in_stall))
		else $error("result with no causing transfer");

endmodule

bind life_generation_row_stencil_unit lgrs_checker u_lgrs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
